[rtl/msh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msh_pkg
// Shared types, widths and constants for the magnetometer heading block.
// ----------------------------------------------------------------------------
package msh_pkg;

  localparam int unsigned SampleW = 18;
  localparam int unsigned ScaleW  = 16;
  localparam int unsigned CalW    = 23;
  localparam int unsigned HeadW   = 15;
  localparam int unsigned ErrW    = 16;
  localparam int unsigned CntW    = 8;
  localparam int unsigned StatW   = 3;
  localparam int unsigned IdxW    = 3;

  localparam logic [CntW-1:0] DiscardSamples = 8'd20;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_READY  = 3'd1,
    ST_READ_ERROR = 3'd2,
    ST_DISCARD    = 3'd3,
    ST_RANGE      = 3'd4,
    ST_RESTART    = 3'd5
  } msh_status_e;

  // item classes decided by the front end
  typedef enum logic [2:0] {
    K_RESTART    = 3'd0,
    K_NOT_READY  = 3'd1,
    K_READ_ERROR = 3'd2,
    K_DISCARD    = 3'd3,
    K_SAMPLE     = 3'd4
  } msh_kind_e;

  // configuration register indexes
  typedef enum logic [IdxW-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_SCALE_X  = 3'd3,
    REG_SCALE_Y  = 3'd4,
    REG_SCALE_Z  = 3'd5,
    REG_MIN_MAG  = 3'd6,
    REG_MAX_MAG  = 3'd7
  } msh_reg_e;

  typedef struct packed {
    msh_kind_e                  kind;
    logic signed [SampleW-1:0]  x;
    logic signed [SampleW-1:0]  y;
    logic signed [SampleW-1:0]  z;
  } msh_job_t;

  typedef struct packed {
    logic signed [SampleW-1:0] offset_x;
    logic signed [SampleW-1:0] offset_y;
    logic signed [SampleW-1:0] offset_z;
    logic [ScaleW-1:0]         scale_x;
    logic [ScaleW-1:0]         scale_y;
    logic [ScaleW-1:0]         scale_z;
    logic [SampleW-1:0]        min_mag;
    logic [SampleW-1:0]        max_mag;
  } msh_cfg_t;

  // arctangent table in 1/16384 degree
  function automatic logic [19:0] cordic_angle(input logic [4:0] idx);
    logic [19:0] a;
    unique case (idx)
      5'd0:    a = 20'd737280;
      5'd1:    a = 20'd435242;
      5'd2:    a = 20'd229970;
      5'd3:    a = 20'd116736;
      5'd4:    a = 20'd58595;
      5'd5:    a = 20'd29326;
      5'd6:    a = 20'd14667;
      5'd7:    a = 20'd7334;
      5'd8:    a = 20'd3667;
      5'd9:    a = 20'd1833;
      5'd10:   a = 20'd917;
      5'd11:   a = 20'd458;
      5'd12:   a = 20'd229;
      5'd13:   a = 20'd115;
      5'd14:   a = 20'd57;
      5'd15:   a = 20'd29;
      5'd16:   a = 20'd14;
      5'd17:   a = 20'd7;
      5'd18:   a = 20'd4;
      5'd19:   a = 20'd2;
      default: a = 20'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

[rtl/msh_intf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msh_intf
// Sample and result channels, valid/ready with payload.
// ----------------------------------------------------------------------------
interface msh_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic                                data_ready;
  logic                                read_error;
  logic signed [msh_pkg::SampleW-1:0]  sample_x;
  logic signed [msh_pkg::SampleW-1:0]  sample_y;
  logic signed [msh_pkg::SampleW-1:0]  sample_z;

  modport source (output valid, command, data_ready, read_error, sample_x, sample_y,
                  sample_z, input ready);
  modport sink   (input valid, command, data_ready, read_error, sample_x, sample_y,
                  sample_z, output ready);
endinterface

interface msh_out_if;
  logic                             valid;
  logic                             ready;
  logic [msh_pkg::StatW-1:0]        status;
  logic signed [msh_pkg::CalW-1:0]  cal_x;
  logic signed [msh_pkg::CalW-1:0]  cal_y;
  logic signed [msh_pkg::CalW-1:0]  cal_z;
  logic [msh_pkg::HeadW-1:0]        heading;
  logic [msh_pkg::CalW-1:0]         field_strength;
  logic                             valid_res;
  logic [msh_pkg::ErrW-1:0]         err_total;

  modport source (output valid, status, cal_x, cal_y, cal_z, heading, field_strength,
                  valid_res, err_total, input ready);
  modport sink   (input valid, status, cal_x, cal_y, cal_z, heading, field_strength,
                  valid_res, err_total, output ready);
endinterface
`default_nettype wire

[rtl/msh_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msh_front
// Accepts samples, classifies them and keeps the discard counter.
// ----------------------------------------------------------------------------
module msh_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  msh_in_if.sink                 in_if,
  input  wire logic              full_i,
  output logic                   push_o,
  output msh_pkg::msh_job_t      job_o
);

  logic [msh_pkg::CntW-1:0] disc_q, disc_d;

  assign in_if.ready = ~full_i;
  assign push_o      = in_if.valid & ~full_i;

  // classify the item in the same order as its handling
  always_comb begin
    disc_d     = disc_q;
    job_o.x    = in_if.sample_x;
    job_o.y    = in_if.sample_y;
    job_o.z    = in_if.sample_z;
    job_o.kind = msh_pkg::K_SAMPLE;
    priority if (in_if.command) begin
      job_o.kind = msh_pkg::K_RESTART;
      disc_d     = '0;
    end else if (!in_if.data_ready) begin
      job_o.kind = msh_pkg::K_NOT_READY;
    end else if (in_if.read_error) begin
      job_o.kind = msh_pkg::K_READ_ERROR;
    end else if (disc_q < msh_pkg::DiscardSamples) begin
      job_o.kind = msh_pkg::K_DISCARD;
      disc_d     = disc_q + 8'd1;
    end else begin
      job_o.kind = msh_pkg::K_SAMPLE;
    end
  end

  // discard counter advances on transfer only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_q <= '0;
    end else if (push_o) begin
      disc_q <= disc_d;
    end
  end

endmodule
`default_nettype wire

[rtl/msh_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msh_fifo
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module msh_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire msh_pkg::msh_job_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output msh_pkg::msh_job_t      data_o,
  output logic                   empty_o
);

  msh_pkg::msh_job_t mem_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule
`default_nettype wire

[rtl/msh_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msh_back
// Range check, calibration, CORDIC heading and square root magnitude.
// ----------------------------------------------------------------------------
module msh_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire msh_pkg::msh_cfg_t cfg_i,
  input  wire logic              empty_i,
  input  wire msh_pkg::msh_job_t job_i,
  output logic                   pop_o,
  msh_out_if.source              out_if
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RANGE = 8'b0000_0010,
    S_CAL   = 8'b0000_0100,
    S_MAG   = 8'b0000_1000,
    S_PREP  = 8'b0001_0000,
    S_CORD  = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  localparam logic signed [24:0] HalfTurn = 25'sd2949120;
  localparam logic signed [24:0] FullTurn = 25'sd5898240;
  localparam logic [14:0]        HeadWrap = 15'd23040;

  state_e                state_q;
  logic [4:0]            cnt_q;
  msh_pkg::msh_job_t     job_q;
  msh_pkg::msh_status_e  status_q;
  logic signed [22:0]    hx_q, hy_q, hz_q;
  logic [14:0]           head_q;
  logic [22:0]           str_q;
  logic                  hvalid_q;
  logic [15:0]           err_q;
  logic                  out_vld_q;

  logic [45:0]           acc_q;
  logic [35:0]           minsq_q, maxsq_q;
  logic signed [35:0]    prod_q;
  logic signed [33:0]    cx_q, cy_q;
  logic signed [24:0]    ang_q;
  logic                  zero_q;
  logic [45:0]           rad_q;
  logic [26:0]           rem_q;
  logic [22:0]           root_q;

  // shared squaring unit
  logic signed [22:0]    sq_op;
  logic signed [45:0]    sq_prod;
  always_comb begin
    if (state_q == S_RANGE) begin
      unique case (cnt_q)
        5'd0:    sq_op = {{5{job_q.x[17]}}, job_q.x};
        5'd1:    sq_op = {{5{job_q.y[17]}}, job_q.y};
        5'd2:    sq_op = {{5{job_q.z[17]}}, job_q.z};
        5'd3:    sq_op = {5'd0, cfg_i.min_mag};
        default: sq_op = {5'd0, cfg_i.max_mag};
      endcase
    end else begin
      unique case (cnt_q)
        5'd0:    sq_op = hx_q;
        5'd1:    sq_op = hy_q;
        default: sq_op = hz_q;
      endcase
    end
    sq_prod = sq_op * sq_op;
  end

  logic reject;
  assign reject = (acc_q < {10'd0, minsq_q}) || (acc_q > {10'd0, maxsq_q});

  // offset and gain multiply, one axis a cycle
  logic signed [17:0] cal_s, cal_off;
  logic [15:0]        cal_scale;
  logic signed [18:0] cal_dif;
  logic signed [35:0] cal_prod;
  always_comb begin
    unique case (cnt_q)
      5'd0: begin
        cal_s = job_q.x; cal_off = cfg_i.offset_x; cal_scale = cfg_i.scale_x;
      end
      5'd1: begin
        cal_s = job_q.y; cal_off = cfg_i.offset_y; cal_scale = cfg_i.scale_y;
      end
      default: begin
        cal_s = job_q.z; cal_off = cfg_i.offset_z; cal_scale = cfg_i.scale_z;
      end
    endcase
    cal_dif  = {cal_s[17], cal_s} - {cal_off[17], cal_off};
    cal_prod = cal_dif * $signed({1'b0, cal_scale});
  end

  // rounding and saturation of the registered product
  logic signed [35:0] cal_rnd;
  logic signed [22:0] cal_sat;
  always_comb begin
    cal_rnd = (prod_q + 36'sd2048) >>> 12;
    if (cal_rnd > 36'sd4194303) begin
      cal_sat = 23'sd4194303;
    end else if (cal_rnd < -36'sd4194304) begin
      cal_sat = -23'sd4194304;
    end else begin
      cal_sat = cal_rnd[22:0];
    end
  end

  // cordic vectoring step
  logic signed [33:0] cdx, cdy, px, py;
  logic signed [24:0] ctab;
  always_comb begin
    cdx  = cy_q >>> cnt_q;
    cdy  = cx_q >>> cnt_q;
    ctab = $signed({5'd0, msh_pkg::cordic_angle(cnt_q)});
    px   = {{11{hx_q[22]}}, hx_q};
    py   = {{11{hy_q[22]}}, hy_q};
  end

  // square root digit step
  logic [26:0] rem_t, trial;
  always_comb begin
    rem_t = {rem_q[24:0], rad_q[45:44]};
    trial = {2'd0, root_q, 2'b01};
  end

  // heading wrap and rounding, magnitude rounding
  logic signed [24:0] ang_a, ang_b;
  logic [22:0]        hd_sum;
  logic [14:0]        hd_val;
  logic [23:0]        str_r;
  always_comb begin
    ang_a  = (ang_q < 25'sd0) ? ang_q + FullTurn : ang_q;
    ang_b  = (ang_a >= FullTurn) ? ang_a - FullTurn : ang_a;
    hd_sum = ang_b[22:0] + 23'd128;
    hd_val = (hd_sum[22:8] == HeadWrap) ? 15'd0 : hd_sum[22:8];
    str_r  = (rem_q > {4'd0, root_q}) ? {1'b0, root_q} + 24'd1 : {1'b0, root_q};
  end

  assign pop_o = (state_q == S_IDLE) && !empty_i;

  logic out_load;
  assign out_load = (state_q == S_DONE) && (!out_vld_q || out_if.ready);

  // sequencer and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      status_q  <= msh_pkg::ST_OK;
      hx_q      <= '0;
      hy_q      <= '0;
      hz_q      <= '0;
      head_q    <= '0;
      str_q     <= '0;
      hvalid_q  <= 1'b0;
      err_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            cnt_q <= '0;
            unique case (job_i.kind)
              msh_pkg::K_RESTART: begin
                status_q <= msh_pkg::ST_RESTART;
                state_q  <= S_DONE;
              end
              msh_pkg::K_NOT_READY: begin
                status_q <= msh_pkg::ST_NOT_READY;
                state_q  <= S_DONE;
              end
              msh_pkg::K_READ_ERROR: begin
                if (err_q != 16'hFFFF) err_q <= err_q + 16'd1;
                hvalid_q <= 1'b0;
                status_q <= msh_pkg::ST_READ_ERROR;
                state_q  <= S_DONE;
              end
              msh_pkg::K_DISCARD: begin
                hvalid_q <= 1'b0;
                status_q <= msh_pkg::ST_DISCARD;
                state_q  <= S_DONE;
              end
              default: state_q <= S_RANGE;
            endcase
          end
        end
        S_RANGE: begin
          if (cnt_q == 5'd5) begin
            cnt_q <= '0;
            if (reject) begin
              if (err_q != 16'hFFFF) err_q <= err_q + 16'd1;
              hvalid_q <= 1'b0;
              status_q <= msh_pkg::ST_RANGE;
              state_q  <= S_DONE;
            end else begin
              state_q <= S_CAL;
            end
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_CAL: begin
          unique case (cnt_q)
            5'd1:    hx_q <= cal_sat;
            5'd2:    hy_q <= cal_sat;
            5'd3:    hz_q <= cal_sat;
            default: ;
          endcase
          if (cnt_q == 5'd3) begin
            cnt_q   <= '0;
            state_q <= S_MAG;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_MAG: begin
          if (cnt_q == 5'd2) begin
            cnt_q   <= '0;
            state_q <= S_PREP;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_PREP: begin
          cnt_q   <= '0;
          state_q <= S_CORD;
        end
        S_CORD: begin
          if (cnt_q == 5'd22) begin
            state_q <= S_FIN;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        S_FIN: begin
          head_q   <= zero_q ? 15'd0 : hd_val;
          str_q    <= str_r[23] ? 23'h7FFFFF : str_r[22:0];
          hvalid_q <= 1'b1;
          status_q <= msh_pkg::ST_OK;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    unique case (state_q)
      S_IDLE: acc_q <= '0;
      S_RANGE: begin
        unique case (cnt_q)
          5'd0, 5'd1, 5'd2: acc_q <= acc_q + sq_prod[45:0];
          5'd3:             minsq_q <= sq_prod[35:0];
          5'd4: begin
            maxsq_q <= sq_prod[35:0];
          end
          default:          acc_q <= '0;
        endcase
      end
      S_CAL: prod_q <= cal_prod;
      S_MAG: acc_q <= acc_q + sq_prod[45:0];
      S_PREP: begin
        zero_q <= (hx_q == 23'sd0) && (hy_q == 23'sd0);
        if (hx_q < 23'sd0) begin
          cx_q  <= (-px) <<< 8;
          cy_q  <= (-py) <<< 8;
          ang_q <= HalfTurn;
        end else begin
          cx_q  <= px <<< 8;
          cy_q  <= py <<< 8;
          ang_q <= 25'sd0;
        end
        rad_q  <= acc_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      S_CORD: begin
        if (cnt_q < 5'd20) begin
          if (!cy_q[33]) begin
            cx_q  <= cx_q + cdx;
            cy_q  <= cy_q - cdy;
            ang_q <= ang_q + ctab;
          end else begin
            cx_q  <= cx_q - cdx;
            cy_q  <= cy_q + cdy;
            ang_q <= ang_q - ctab;
          end
        end
        rad_q <= {rad_q[43:0], 2'b00};
        if (rem_t >= trial) begin
          rem_q  <= rem_t - trial;
          root_q <= {root_q[21:0], 1'b1};
        end else begin
          rem_q  <= rem_t;
          root_q <= {root_q[21:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_if.status         <= status_q;
      out_if.cal_x          <= hx_q;
      out_if.cal_y          <= hy_q;
      out_if.cal_z          <= hz_q;
      out_if.heading        <= head_q;
      out_if.field_strength <= str_q;
      out_if.valid_res      <= hvalid_q;
      out_if.err_total      <= err_q;
    end
  end

  assign out_if.valid = out_vld_q;

endmodule
`default_nettype wire

[rtl/magnetometer_sample_heading_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_sample_heading_top
// Magnetometer sample conditioning with hard-iron calibration and heading.
//
//   channel  direction  carries
//   in_if    sink       command, flags, raw x/y/z sample
//   out_if   source     status, calibrated x/y/z, heading, strength, counters
//   cfg      write      offsets, gains, magnitude bounds
//
// Status-only items go straight to the output stage. A good sample passes the
// range check, calibration, the magnitude sum, the shared CORDIC and square
// root sequence, one step a cycle, and a final step to wrap and round the
// heading; a range rejection ends after the range check.
// The back end handles one item at a time; a two-entry queue lets the front
// end keep taking items meanwhile. Reset clears all held results and counters.
// ----------------------------------------------------------------------------
module magnetometer_sample_heading_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  msh_in_if.sink                          in_if,
  msh_out_if.source                       out_if,
  input  wire logic                       cfg_we_i,
  input  wire logic [msh_pkg::IdxW-1:0]   cfg_idx_i,
  input  wire logic [msh_pkg::SampleW-1:0] cfg_data_i
);

  msh_pkg::msh_cfg_t cfg_q;
  msh_pkg::msh_job_t push_job, pop_job;
  logic              push, full, pop, empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
      cfg_q.offset_z <= '0;
      cfg_q.scale_x  <= 16'd4096;
      cfg_q.scale_y  <= 16'd4096;
      cfg_q.scale_z  <= 16'd4096;
      cfg_q.min_mag  <= 18'd2;
      cfg_q.max_mag  <= 18'd160000;
    end else if (cfg_we_i) begin
      unique case (msh_pkg::msh_reg_e'(cfg_idx_i))
        msh_pkg::REG_OFFSET_X: cfg_q.offset_x <= cfg_data_i;
        msh_pkg::REG_OFFSET_Y: cfg_q.offset_y <= cfg_data_i;
        msh_pkg::REG_OFFSET_Z: cfg_q.offset_z <= cfg_data_i;
        msh_pkg::REG_SCALE_X:  cfg_q.scale_x  <= cfg_data_i[15:0];
        msh_pkg::REG_SCALE_Y:  cfg_q.scale_y  <= cfg_data_i[15:0];
        msh_pkg::REG_SCALE_Z:  cfg_q.scale_z  <= cfg_data_i[15:0];
        msh_pkg::REG_MIN_MAG:  cfg_q.min_mag  <= cfg_data_i;
        msh_pkg::REG_MAX_MAG:  cfg_q.max_mag  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end
  msh_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  // item queue
  msh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_job),
    .empty_o (empty)
  );

  // back end
  msh_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .job_i   (pop_job),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule
`default_nettype wire

[test/magnetometer_sample_heading_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_sample_heading_checker
// Watches the sample, result and register channels of the heading block,
// predicts every result from its own copy of the state and the registers,
// and compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module magnetometer_sample_heading_checker
  import msh_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  msh_in_if                    in_mon,
  msh_out_if                   out_mon,
  input  wire logic            cfg_we_i,
  input  wire logic [IdxW-1:0] cfg_idx_i,
  input  wire logic [SampleW-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    msh_status_e          status;
    logic [CalW-1:0]      cal_x;
    logic [CalW-1:0]      cal_y;
    logic [CalW-1:0]      cal_z;
    logic [HeadW-1:0]     heading;
    logic [CalW-1:0]      strength;
    logic                 valid_res;
    logic [ErrW-1:0]      errors;
  } heading_result_t;

  localparam longint HalfTurn  = 2949120;
  localparam longint FullTurn  = 5898240;
  localparam longint HeadWrap  = 23040;
  localparam longint CalHi     = 4194303;
  localparam longint CalLo     = -4194304;
  localparam longint StrMax    = 8388607;

  // arctangent steps in 1/16384 degree
  localparam longint AtanStep [20] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7, 4, 2
  };

  heading_result_t result_q [$];

  // predicted block state and register copy
  msh_cfg_t         regs;
  logic [CntW-1:0]  skip_cnt;
  longint           hold_x, hold_y, hold_z;
  logic [HeadW-1:0] hold_head;
  logic [CalW-1:0]  hold_str;
  logic             hold_valid;
  logic [ErrW-1:0]  err_cnt;

  assign pending_o = result_q.size();

  function automatic longint calibrate_axis(logic signed [SampleW-1:0] s,
                                            logic signed [SampleW-1:0] off,
                                            logic [ScaleW-1:0] gain);
    longint r;
    r = ((longint'(s) - longint'(off)) * longint'(gain) + 2048) >>> 12;
    if (r > CalHi) r = CalHi;
    if (r < CalLo) r = CalLo;
    return r;
  endfunction

  function automatic logic [HeadW-1:0] compass_angle(longint cx, longint cy);
    longint x, y, a, z, dx, dy;
    longint h;
    x = cx;
    y = cy;
    a = 0;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      a = HalfTurn;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + AtanStep[i];
      end else begin
        x = x - dx; y = y + dy; z = z - AtanStep[i];
      end
    end
    a = a + z;
    if (a < 0) a = a + FullTurn;
    if (a >= FullTurn) a = a - FullTurn;
    h = (a + 128) >>> 8;
    if (h >= HeadWrap) h = h - HeadWrap;
    return h[HeadW-1:0];
  endfunction

  // rounded square root of the squared calibrated vector length
  function automatic logic [CalW-1:0] vector_length(longint unsigned n);
    longint unsigned rem, r, b;
    rem = n;
    r = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n - r * r > r) r = r + 1;
    if (r > StrMax) r = StrMax;
    return r[CalW-1:0];
  endfunction

  function automatic void bump_errors();
    if (err_cnt != '1) err_cnt = err_cnt + ErrW'(1);
  endfunction

  // work out the result of one accepted sample transfer
  function automatic heading_result_t predict_heading();
    heading_result_t res;
    longint sx, sy, sz, sq, lo2, hi2;
    msh_status_e st;
    sx = longint'(in_mon.sample_x);
    sy = longint'(in_mon.sample_y);
    sz = longint'(in_mon.sample_z);
    if (in_mon.command) begin
      skip_cnt = '0;
      st = ST_RESTART;
    end else if (!in_mon.data_ready) begin
      st = ST_NOT_READY;
    end else if (in_mon.read_error) begin
      bump_errors();
      hold_valid = 1'b0;
      st = ST_READ_ERROR;
    end else if (skip_cnt < DiscardSamples) begin
      skip_cnt = skip_cnt + CntW'(1);
      hold_valid = 1'b0;
      st = ST_DISCARD;
    end else begin
      sq  = sx * sx + sy * sy + sz * sz;
      lo2 = longint'(regs.min_mag) * longint'(regs.min_mag);
      hi2 = longint'(regs.max_mag) * longint'(regs.max_mag);
      if (sq < lo2 || sq > hi2) begin
        bump_errors();
        hold_valid = 1'b0;
        st = ST_RANGE;
      end else begin
        hold_x = calibrate_axis(in_mon.sample_x, regs.offset_x, regs.scale_x);
        hold_y = calibrate_axis(in_mon.sample_y, regs.offset_y, regs.scale_y);
        hold_z = calibrate_axis(in_mon.sample_z, regs.offset_z, regs.scale_z);
        hold_head = compass_angle(hold_x, hold_y);
        hold_str = vector_length(hold_x * hold_x + hold_y * hold_y + hold_z * hold_z);
        hold_valid = 1'b1;
        st = ST_OK;
      end
    end
    res.status    = st;
    res.cal_x     = hold_x[CalW-1:0];
    res.cal_y     = hold_y[CalW-1:0];
    res.cal_z     = hold_z[CalW-1:0];
    res.heading   = hold_head;
    res.strength  = hold_str;
    res.valid_res = hold_valid;
    res.errors    = err_cnt;
    return res;
  endfunction

  // predict on sample transfers, compare on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    heading_result_t want, got;
    if (!rst_ni) begin
      regs.offset_x <= '0;
      regs.offset_y <= '0;
      regs.offset_z <= '0;
      regs.scale_x  <= 16'd4096;
      regs.scale_y  <= 16'd4096;
      regs.scale_z  <= 16'd4096;
      regs.min_mag  <= 18'd2;
      regs.max_mag  <= 18'd160000;
      skip_cnt      = '0;
      hold_x        = 0;
      hold_y        = 0;
      hold_z        = 0;
      hold_head     = '0;
      hold_str      = '0;
      hold_valid    = 1'b0;
      err_cnt       = '0;
      result_q.delete();
      fail_count_o  <= 0;
      checked_o     <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (msh_reg_e'(cfg_idx_i))
          REG_OFFSET_X: regs.offset_x <= cfg_data_i;
          REG_OFFSET_Y: regs.offset_y <= cfg_data_i;
          REG_OFFSET_Z: regs.offset_z <= cfg_data_i;
          REG_SCALE_X:  regs.scale_x  <= cfg_data_i[ScaleW-1:0];
          REG_SCALE_Y:  regs.scale_y  <= cfg_data_i[ScaleW-1:0];
          REG_SCALE_Z:  regs.scale_z  <= cfg_data_i[ScaleW-1:0];
          REG_MIN_MAG:  regs.min_mag  <= cfg_data_i;
          REG_MAX_MAG:  regs.max_mag  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) result_q.push_back(predict_heading());
      if (out_mon.valid && out_mon.ready) begin
        got.status    = msh_status_e'(out_mon.status);
        got.cal_x     = out_mon.cal_x;
        got.cal_y     = out_mon.cal_y;
        got.cal_z     = out_mon.cal_z;
        got.heading   = out_mon.heading;
        got.strength  = out_mon.field_strength;
        got.valid_res = out_mon.valid_res;
        got.errors    = out_mon.err_total;
        checked_o <= checked_o + 1;
        if (result_q.size() == 0) begin
          $display("%0t: result transfer with nothing predicted: status %0d",
                   $time, got.status);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = result_q.pop_front();
          if (want != got) begin
            $display({"%0t: result differs, expected ",
                      "st=%0d x=%0d y=%0d z=%0d hd=%0d str=%0d v=%0d err=%0d"},
                     $time, want.status, $signed(want.cal_x), $signed(want.cal_y),
                     $signed(want.cal_z), want.heading, want.strength, want.valid_res,
                     want.errors);
            $display({"%0t:                  actual   ",
                      "st=%0d x=%0d y=%0d z=%0d hd=%0d str=%0d v=%0d err=%0d"},
                     $time, got.status, $signed(got.cal_x), $signed(got.cal_y),
                     $signed(got.cal_z), got.heading, got.strength, got.valid_res,
                     got.errors);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[test/magnetometer_sample_heading_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_sample_heading_top_tb
// Drives directed and random magnetometer samples and register settings into
// the heading block with random idling on both channels, and reports the
// verdict from the checker that sits beside the block.
// ----------------------------------------------------------------------------
module magnetometer_sample_heading_top_tb;
  import msh_pkg::*;

  localparam int CycleLimit = 1000000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [IdxW-1:0]    cfg_idx;
  logic [SampleW-1:0] cfg_data;
  int                 fail_count, pending, checked, sent, cycles;
  logic               idle_on;
  logic               hold_req;
  logic               hold_done;
  int                 stall_cnt, hold_cnt;

  msh_in_if  in_ch ();
  msh_out_if out_ch ();

  magnetometer_sample_heading_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  magnetometer_sample_heading_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("magnetometer_sample_heading_top: mismatch");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= 300;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_cnt <= $urandom_range(0, 11);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one sample transfer, with an optional gap before it
  task automatic send_sample(logic cmd, logic dr, logic re,
                             logic [SampleW-1:0] x, logic [SampleW-1:0] y,
                             logic [SampleW-1:0] z);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.data_ready <= dr;
    in_ch.read_error <= re;
    in_ch.sample_x   <= x;
    in_ch.sample_y   <= y;
    in_ch.sample_z   <= z;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // stop offering and let every predicted result come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [SampleW-1:0] ox, logic [SampleW-1:0] oy,
                            logic [SampleW-1:0] oz, logic [ScaleW-1:0] gx,
                            logic [ScaleW-1:0] gy, logic [ScaleW-1:0] gz,
                            logic [SampleW-1:0] lo, logic [SampleW-1:0] hi);
    logic [SampleW-1:0] vals [8];
    vals = '{ox, oy, oz, {2'b00, gx}, {2'b00, gy}, {2'b00, gz}, lo, hi};
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= msh_reg_e'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] pick_axis();
    int unsigned m;
    m = $urandom_range(0, 9);
    if (m < 6) return SampleW'($urandom_range(0, 8000)) - SampleW'(4000);
    if (m < 8) return SampleW'($urandom);
    return m[0] ? 18'h1FFFF : 18'h20000;
  endfunction

  task automatic random_sample();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 4)
      send_sample(1'b1, 1'($urandom), 1'($urandom), SampleW'($urandom),
                  SampleW'($urandom), SampleW'($urandom));
    else if (k < 8)
      send_sample(1'b0, 1'b0, 1'($urandom), SampleW'($urandom), SampleW'($urandom),
                  SampleW'($urandom));
    else if (k < 13)
      send_sample(1'b0, 1'b1, 1'b1, SampleW'($urandom), SampleW'($urandom),
                  SampleW'($urandom));
    else
      send_sample(1'b0, 1'b1, 1'b0, pick_axis(), pick_axis(), pick_axis());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.data_ready = 1'b0;
    in_ch.read_error = 1'b0;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    in_ch.sample_z = '0;
    out_ch.ready = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    hold_done = 1'b0;
    stall_cnt = 0;
    hold_cnt = 0;
    sent = 0;
    cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: flags, restart, the discard window, range edges
    send_sample(1'b0, 1'b0, 1'b1, 18'd5, 18'd5, 18'd5);
    send_sample(1'b1, 1'b1, 1'b1, 18'd7, 18'd7, 18'd7);
    send_sample(1'b0, 1'b1, 1'b1, 18'd100, 18'd0, 18'd0);
    repeat (20) send_sample(1'b0, 1'b1, 1'b0, 18'd300, -18'sd200, 18'd50);
    send_sample(1'b0, 1'b1, 1'b0, 18'h1FFFF, 18'h20000, 18'h1FFFF);
    send_sample(1'b0, 1'b1, 1'b0, 18'd0, 18'd0, 18'd0);
    send_sample(1'b0, 1'b1, 1'b0, -18'sd100, 18'd0, 18'd0);
    send_sample(1'b0, 1'b1, 1'b0, 18'd0, 18'd150, -18'sd70);
    send_sample(1'b1, 1'b0, 1'b0, 18'd0, 18'd0, 18'd0);
    drain();
    // zero bound lets the zero vector through
    write_regs(18'd0, 18'd0, 18'd0, 16'd4096, 16'd4096, 16'd4096, 18'd0, 18'h3FFFF);
    repeat (20) send_sample(1'b0, 1'b1, 1'b0, 18'd10, 18'd10, 18'd10);
    send_sample(1'b0, 1'b1, 1'b0, 18'd0, 18'd0, 18'd5);
    send_sample(1'b0, 1'b1, 1'b0, 18'd0, 18'd0, 18'd0);

    // random phases, each with its own register setting
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: write_regs(18'd0, 18'd0, 18'd0, 16'd4096, 16'd4096, 16'd4096, 18'd0, 18'h3FFFF);
        1: write_regs(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      18'd0, 18'h3FFFF);
        2: write_regs(18'h20000, 18'h20000, 18'h20000, 16'd0, 16'd0, 16'd0,
                      18'd5000, 18'd1000);
        default: write_regs(SampleW'($urandom_range(0, 4000)) - SampleW'(2000),
                            SampleW'($urandom_range(0, 4000)) - SampleW'(2000),
                            SampleW'($urandom), ScaleW'($urandom_range(1024, 12288)),
                            ScaleW'($urandom_range(1024, 12288)), ScaleW'($urandom),
                            SampleW'($urandom_range(0, 500)),
                            SampleW'($urandom_range(3000, 262143)));
      endcase
      if (p == 5) idle_on = 1'b0;
      for (int n = 0; n < (p == 2 ? 120 : 250); n++) begin
        if (p == 1 && n == 10) hold_req = 1'b1;
        random_sample();
      end
    end
    drain();

    $display("covered %0d sample transfers and %0d checked results over six register settings",
             sent, checked);
    $display("directed flags, discards, range edges, saturation, stalls and a long hold-off");
    if (fail_count == 0) begin
      $display("magnetometer_sample_heading_top: match");
    end else begin
      $display("magnetometer_sample_heading_top: mismatch");
    end
    $finish;
  end

endmodule

[magnetometer_sample_heading_top.f]
rtl/msh_pkg.sv
rtl/msh_intf.sv
rtl/msh_front.sv
rtl/msh_fifo.sv
rtl/msh_back.sv
rtl/magnetometer_sample_heading_top.sv
test/magnetometer_sample_heading_checker.sv
test/magnetometer_sample_heading_top_tb.sv
